>>> hw/rtl/kchd_pkg.sv
// shared types and constants of the key chord hotkey detector
`default_nettype none

package kchd_pkg;

  localparam int KEY_W        = 10;
  localparam int CLASS_W      = 5;
  localparam int ACTION_W     = 2;
  localparam int PAT_W        = 32;
  localparam int PAT_SLOTS    = 3;
  localparam int PAT_LEN_W    = 2;
  localparam int HITS_W       = 3;
  localparam int CFG_INDEX_W  = 2;
  localparam int CMD_QUEUE_DEPTH = 2;

  localparam logic [CLASS_W-1:0] KEY_CLASS = 5'd1;

  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PRESS   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REPEAT  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_OTHER   = 2'd3;

  // register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] REG_CHORD_A    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHORD_B    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHORD_C    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXIT_CHORD = 2'd3;

  // reset patterns: length in bits 1:0, keys from bit 2 up
  localparam logic [PAT_W-1:0] CHORD_A_RESET    = 32'd73830;     // 25, 18
  localparam logic [PAT_W-1:0] CHORD_B_RESET    = 32'd104923323; // 46, 16, 25
  localparam logic [PAT_W-1:0] CHORD_C_RESET    = 32'd196674;    // 16, 48
  localparam logic [PAT_W-1:0] EXIT_CHORD_RESET = 32'd184394;    // 18, 45

  typedef enum logic [1:0] {
    OP_IGNORE,
    OP_RELEASE,
    OP_PRESS,
    OP_REPEAT
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_RELEASED,
    KIND_PRESSED,
    KIND_REPEAT
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_UPDATE,
    B_MATCH
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [KEY_W-1:0]  key;
    logic [HITS_W-1:0] hits;
    logic              term;
    logic              ovf;
  } res_t;

  typedef struct packed {
    logic [PAT_W-1:0] chord_a;
    logic [PAT_W-1:0] chord_b;
    logic [PAT_W-1:0] chord_c;
    logic [PAT_W-1:0] exit_chord;
  } pat_set_t;

endpackage

`default_nettype wire

>>> hw/rtl/kchd_front.sv
// front end: classifies incoming key events into commands
`default_nettype none

module kchd_front (
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [kchd_pkg::CLASS_W-1:0]     event_class,
  input  wire logic [kchd_pkg::ACTION_W-1:0]    action,
  input  wire logic [kchd_pkg::KEY_W-1:0]       key_code,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output kchd_pkg::cmd_t                        q_cmd
);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_cmd.key = key_code;
    q_cmd.op  = kchd_pkg::OP_IGNORE;
    if (event_class == kchd_pkg::KEY_CLASS) begin
      unique case (action)
        kchd_pkg::ACT_RELEASE: q_cmd.op = kchd_pkg::OP_RELEASE;
        kchd_pkg::ACT_PRESS:   q_cmd.op = kchd_pkg::OP_PRESS;
        kchd_pkg::ACT_REPEAT:  q_cmd.op = kchd_pkg::OP_REPEAT;
        default:               q_cmd.op = kchd_pkg::OP_IGNORE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kchd_queue.sv
// short command queue between front and back
`default_nettype none

module kchd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire kchd_pkg::cmd_t din,
  output logic                full,
  input  wire logic           pop,
  output kchd_pkg::cmd_t      dout,
  output logic                empty
);

  localparam int DEPTH = kchd_pkg::CMD_QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(DEPTH + 1);

  kchd_pkg::cmd_t   slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [FW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == FW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kchd_back.sv
// back end: held and repeat lists, chord compare and result register
`default_nettype none

module kchd_back #(
  parameter int HELD_DEPTH   = 6,
  parameter int REPEAT_DEPTH = 6,
  parameter int CHORD_KEYS   = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kchd_pkg::pat_set_t pats,
  input  wire logic               q_empty,
  input  wire kchd_pkg::cmd_t     q_cmd,
  output logic                    q_pop,
  input  wire logic               res_pop,
  output logic                    res_valid,
  output kchd_pkg::res_t          res
);

  localparam int HCW = $clog2(HELD_DEPTH + 1);
  localparam int RCW = $clog2(REPEAT_DEPTH + 1);
  localparam int KW  = kchd_pkg::KEY_W;

  kchd_pkg::back_state_t state;
  kchd_pkg::back_state_t state_next;

  logic [KW-1:0]   held [HELD_DEPTH];
  logic [HCW-1:0]  held_count;
  logic [KW-1:0]   rep [REPEAT_DEPTH];
  logic [RCW-1:0]  rep_count;

  kchd_pkg::cmd_t  cmd;
  kchd_pkg::kind_t kind;
  logic            ovf;
  kchd_pkg::kind_t upd_kind;
  logic            upd_ovf;

  logic [HELD_DEPTH-1:0]   held_hit;
  logic [HELD_DEPTH-1:0]   held_pre;
  logic [REPEAT_DEPTH-1:0] rep_hit;
  logic [REPEAT_DEPTH-1:0] rep_pre;
  logic                    held_found;
  logic                    rep_found;
  logic                    held_room;
  logic                    rep_room;

  logic [kchd_pkg::PAT_W-1:0] pat [4];
  logic [3:0]                 pat_hit;
  logic                       load;

  // first-match search over both lists
  always_comb begin
    for (int j = 0; j < HELD_DEPTH; j++) begin
      held_hit[j] = (HCW'(j) < held_count) && (held[j] == cmd.key);
    end
    held_pre[0] = held_hit[0];
    for (int j = 1; j < HELD_DEPTH; j++) begin
      held_pre[j] = held_pre[j-1] | held_hit[j];
    end
    for (int j = 0; j < REPEAT_DEPTH; j++) begin
      rep_hit[j] = (RCW'(j) < rep_count) && (rep[j] == cmd.key);
    end
    rep_pre[0] = rep_hit[0];
    for (int j = 1; j < REPEAT_DEPTH; j++) begin
      rep_pre[j] = rep_pre[j-1] | rep_hit[j];
    end
  end

  assign held_found = held_pre[HELD_DEPTH-1];
  assign rep_found  = rep_pre[REPEAT_DEPTH-1];
  assign held_room  = held_count < HCW'(HELD_DEPTH);
  assign rep_room   = rep_count < RCW'(REPEAT_DEPTH);

  always_comb begin
    upd_kind = kchd_pkg::KIND_NONE;
    upd_ovf  = 1'b0;
    case (cmd.op)
      kchd_pkg::OP_RELEASE: upd_kind = kchd_pkg::KIND_RELEASED;
      kchd_pkg::OP_PRESS: begin
        upd_kind = kchd_pkg::KIND_PRESSED;
        upd_ovf  = !held_room;
      end
      kchd_pkg::OP_REPEAT: begin
        if (!rep_found) begin
          upd_kind = kchd_pkg::KIND_REPEAT;
          upd_ovf  = !rep_room;
        end
      end
      default: ;
    endcase
  end

  // exact compare of the held list against each pattern
  assign pat[0] = pats.chord_a;
  assign pat[1] = pats.chord_b;
  assign pat[2] = pats.chord_c;
  assign pat[3] = pats.exit_chord;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      pat_hit[p] = (32'(pat[p][1:0]) <= CHORD_KEYS) && (HCW'(pat[p][1:0]) == held_count);
      for (int i = 0; i < kchd_pkg::PAT_SLOTS; i++) begin
        if (2'(i) < pat[p][1:0]) begin
          pat_hit[p] = pat_hit[p] && (held[i] == pat[p][2 + KW*i +: KW]);
        end
      end
    end
  end

  assign load = (state == kchd_pkg::B_MATCH) && (!res_valid || res_pop);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      kchd_pkg::B_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty) begin
          state_next = kchd_pkg::B_UPDATE;
        end
      end
      kchd_pkg::B_UPDATE: state_next = kchd_pkg::B_MATCH;
      kchd_pkg::B_MATCH: begin
        if (load) begin
          state_next = kchd_pkg::B_IDLE;
        end
      end
      default: state_next = kchd_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kchd_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control: counts and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      rep_count  <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (state == kchd_pkg::B_UPDATE) begin
        case (cmd.op)
          kchd_pkg::OP_RELEASE: begin
            if (held_found) begin
              held_count <= held_count - 1'b1;
            end
            if (rep_found) begin
              rep_count <= rep_count - 1'b1;
            end
          end
          kchd_pkg::OP_PRESS: begin
            if (held_room) begin
              held_count <= held_count + 1'b1;
            end
          end
          kchd_pkg::OP_REPEAT: begin
            if (!rep_found && rep_room) begin
              rep_count <= rep_count + 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload: list entries, command and result
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (state == kchd_pkg::B_UPDATE) begin
      kind <= upd_kind;
      ovf  <= upd_ovf;
      case (cmd.op)
        kchd_pkg::OP_RELEASE: begin
          for (int j = 0; j < HELD_DEPTH - 1; j++) begin
            if (held_pre[j]) begin
              held[j] <= held[j+1];
            end
          end
          for (int j = 0; j < REPEAT_DEPTH - 1; j++) begin
            if (rep_pre[j]) begin
              rep[j] <= rep[j+1];
            end
          end
        end
        kchd_pkg::OP_PRESS: begin
          for (int j = 0; j < HELD_DEPTH; j++) begin
            if (held_count == HCW'(j)) begin
              held[j] <= cmd.key;
            end
          end
        end
        kchd_pkg::OP_REPEAT: begin
          if (!rep_found) begin
            for (int j = 0; j < REPEAT_DEPTH; j++) begin
              if (rep_count == RCW'(j)) begin
                rep[j] <= cmd.key;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (load) begin
      if (cmd.op == kchd_pkg::OP_IGNORE) begin
        res <= '0;
      end else begin
        res.kind <= kind;
        res.key  <= cmd.key;
        res.hits <= pat_hit[2:0];
        res.term <= pat_hit[3];
        res.ovf  <= ovf;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/key_chord_hotkey_detector_unit.sv
// top level of the key chord hotkey detector
//
// usage:
//   events enter as queue beats: drive event_class, action and key_code with
//   push high; a beat is taken at a clock edge where push is high and full low
//   results leave as queue beats: while empty is low the oldest result sits on
//   report_kind, key_out, chord_hits, terminate and overflow; pop takes it
//   the config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
//   chord patterns; cfg_ready is always high, write only while idle
// timing:
//   every event gives exactly one result beat, ignored events give all zeros
//   an accepted event passes the queue, the back end's command register, its
//   kind and overflow registers and the result register; the back end's
//   three-state sequencer (take command, update the lists, compare chords)
//   ends each event before it takes the next; a two-entry command queue lets
//   the front keep taking events while the back waits on a stalled result;
//   when pop stays low the result holds, the queue fills and full rises
// reset (rst, synchronous): lists empty, queue and result register empty,
//   chord registers back to their default patterns
`default_nettype none

module key_chord_hotkey_detector_unit #(
  parameter int HELD_DEPTH   = 6,
  parameter int REPEAT_DEPTH = 6,
  parameter int CHORD_KEYS   = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // event beats in
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [kchd_pkg::CLASS_W-1:0]        event_class,
  input  wire logic [kchd_pkg::ACTION_W-1:0]       action,
  input  wire logic [kchd_pkg::KEY_W-1:0]          key_code,
  // result beats out
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [1:0]                               report_kind,
  output logic [kchd_pkg::KEY_W-1:0]               key_out,
  output logic [kchd_pkg::HITS_W-1:0]              chord_hits,
  output logic                                     terminate,
  output logic                                     overflow,
  // config writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [kchd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [kchd_pkg::PAT_W-1:0]          cfg_data
);

  kchd_pkg::pat_set_t pats;
  kchd_pkg::cmd_t     front_cmd;
  kchd_pkg::cmd_t     q_cmd;
  kchd_pkg::res_t     res;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic               res_valid;
  logic               res_pop;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pats.chord_a    <= kchd_pkg::CHORD_A_RESET;
      pats.chord_b    <= kchd_pkg::CHORD_B_RESET;
      pats.chord_c    <= kchd_pkg::CHORD_C_RESET;
      pats.exit_chord <= kchd_pkg::EXIT_CHORD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kchd_pkg::REG_CHORD_A:    pats.chord_a    <= cfg_data;
        kchd_pkg::REG_CHORD_B:    pats.chord_b    <= cfg_data;
        kchd_pkg::REG_CHORD_C:    pats.chord_c    <= cfg_data;
        kchd_pkg::REG_EXIT_CHORD: pats.exit_chord <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: classify events into commands
  kchd_front u_front (
    .push        (push),
    .full        (full),
    .event_class (event_class),
    .action      (action),
    .key_code    (key_code),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (front_cmd)
  );

  // decoupling queue
  kchd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (front_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_cmd),
    .empty (q_empty)
  );

  // back: list engine, chord compare, result register
  kchd_back #(
    .HELD_DEPTH   (HELD_DEPTH),
    .REPEAT_DEPTH (REPEAT_DEPTH),
    .CHORD_KEYS   (CHORD_KEYS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pats      (pats),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_pop   (res_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  // result side
  assign empty       = !res_valid;
  assign res_pop     = pop && res_valid;
  assign report_kind = res.kind;
  assign key_out     = res.key;
  assign chord_hits  = res.hits;
  assign terminate   = res.term;
  assign overflow    = res.ovf;

endmodule

`default_nettype wire

>>> verif/key_chord_hotkey_detector_unit_tb.sv
// self-checking testbench of the key chord hotkey detector unit
`timescale 1ns / 100ps

module key_chord_hotkey_detector_unit_tb;
  import kchd_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int HELD_DEPTH   = 6;
  localparam int REPEAT_DEPTH = 6;
  localparam int CHORD_KEYS   = 3;
  localparam int MAX_DEPTH    = 6;

  // which of the two shadow lists
  localparam int LIST_HELD   = 0;
  localparam int LIST_REPEAT = 1;

  // cycles with no beat on any channel before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // long receiver hold-off, and the result counts at which it starts
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_1    = 600;
  localparam int HOLD_AT_2    = 1000;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [CLASS_W-1:0]  cls;
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    key;
  } key_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   push = 1'b0;
  logic                   full;
  logic [CLASS_W-1:0]     event_class = '0;
  logic [ACTION_W-1:0]    action = '0;
  logic [KEY_W-1:0]       key_code = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [1:0]             report_kind;
  logic [KEY_W-1:0]       key_out;
  logic [HITS_W-1:0]      chord_hits;
  logic                   terminate;
  logic                   overflow;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [PAT_W-1:0]       cfg_data = '0;

  key_chord_hotkey_detector_unit #(
    .HELD_DEPTH  (HELD_DEPTH),
    .REPEAT_DEPTH(REPEAT_DEPTH),
    .CHORD_KEYS  (CHORD_KEYS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .event_class(event_class),
    .action     (action),
    .key_code   (key_code),
    .empty      (empty),
    .pop        (pop),
    .report_kind(report_kind),
    .key_out    (key_out),
    .chord_hits (chord_hits),
    .terminate  (terminate),
    .overflow   (overflow),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow of the detector: chord registers, held list and repeat list
  // ---------------------------------------------------------------------------
  logic [PAT_W-1:0] chord_regs [4];
  logic [KEY_W-1:0] key_lists [2][MAX_DEPTH];
  int               list_len [2];

  key_event_t     pending_events [$];   // event beats still to be offered
  res_t           expected_reports [$]; // predicted result beats, oldest first
  int             handled_queued;       // queued events that the block acts on
  int             mismatch_count;
  int             reports_taken;
  logic [KEY_W-1:0] key_pool [6];       // keys that chords are built from
  logic [KEY_W-1:0] stray_keys [$];     // keys left pressed by noise

  // key slot i of a packed chord pattern; slots past the top read as zero
  function automatic logic [KEY_W-1:0] chord_slot(logic [PAT_W-1:0] pat, int i);
    int pos;
    pos = PAT_LEN_W + KEY_W * i;
    if (pos >= PAT_W) return '0;
    return KEY_W'(pat >> pos);
  endfunction

  function automatic logic [PAT_W-1:0] make_pattern(logic [PAT_LEN_W-1:0] len,
      logic [KEY_W-1:0] k0, logic [KEY_W-1:0] k1, logic [KEY_W-1:0] k2);
    return {k2, k1, k0, len};
  endfunction

  // the exact held list against one pattern
  function automatic bit chord_matches(logic [PAT_W-1:0] pat);
    int len;
    int i;
    len = 32'(pat[PAT_LEN_W-1:0]);
    if (len > CHORD_KEYS || len != list_len[LIST_HELD]) return 1'b0;
    for (i = 0; i < len; i++)
      if (key_lists[LIST_HELD][i] != chord_slot(pat, i)) return 1'b0;
    return 1'b1;
  endfunction

  // drop the first matching entry and close the gap
  function automatic void remove_first(int which, logic [KEY_W-1:0] key);
    int i;
    int j;
    for (i = 0; i < list_len[which]; i++) begin
      if (key_lists[which][i] == key) begin
        for (j = i; j + 1 < list_len[which]; j++)
          key_lists[which][j] = key_lists[which][j + 1];
        list_len[which]--;
        return;
      end
    end
  endfunction

  // next result beat for one accepted event, updating the shadow lists
  function automatic res_t detect_hotkey(key_event_t ev);
    res_t r;
    bit   seen;
    int   i;
    r = '0;
    // foreign classes and unknown actions leave state alone, all-zero result
    if (ev.cls != KEY_CLASS || ev.act == ACT_OTHER) return r;
    r.key = ev.key;
    case (ev.act)
      ACT_RELEASE: begin
        r.kind = KIND_RELEASED;
        remove_first(LIST_HELD, ev.key);
        remove_first(LIST_REPEAT, ev.key);
      end
      ACT_PRESS: begin
        r.kind = KIND_PRESSED;
        if (list_len[LIST_HELD] < HELD_DEPTH) begin
          key_lists[LIST_HELD][list_len[LIST_HELD]] = ev.key;
          list_len[LIST_HELD]++;
        end else begin
          r.ovf = 1'b1;
        end
      end
      default: begin
        // autorepeat: reported once per hold, held or not
        seen = 1'b0;
        for (i = 0; i < list_len[LIST_REPEAT]; i++)
          if (key_lists[LIST_REPEAT][i] == ev.key) seen = 1'b1;
        if (!seen) begin
          r.kind = KIND_REPEAT;
          if (list_len[LIST_REPEAT] < REPEAT_DEPTH) begin
            key_lists[LIST_REPEAT][list_len[LIST_REPEAT]] = ev.key;
            list_len[LIST_REPEAT]++;
          end else begin
            r.ovf = 1'b1;
          end
        end
      end
    endcase
    r.hits[0] = chord_matches(chord_regs[REG_CHORD_A]);
    r.hits[1] = chord_matches(chord_regs[REG_CHORD_B]);
    r.hits[2] = chord_matches(chord_regs[REG_CHORD_C]);
    r.term    = chord_matches(chord_regs[REG_EXIT_CHORD]);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // event beat driver: bursts of random length with random gaps between them
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin : event_driver
    key_event_t ev;
    if (rst) begin
      push       <= 1'b0;
      burst_left = 4;
      gap_left   = 0;
    end else begin
      // beat taken at this edge: predict it now, in acceptance order
      if (push && !full) begin
        ev = pending_events.pop_front();
        expected_reports.push_back(detect_hotkey(ev));
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          // a third of the bursts follow on with no gap at all
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_events.size() > 0) begin
        push        <= 1'b1;
        event_class <= pending_events[0].cls;
        action      <= pending_events[0].act;
        key_code    <= pending_events[0].key;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result beat monitor: compares each popped beat with the oldest prediction
  // and pops on a stall pattern that switches mode when a random mode timer runs out
  // ---------------------------------------------------------------------------
  int pop_mode;
  int mode_timer;
  int hold_left;

  always @(posedge clk) begin : result_check
    res_t exp_report;
    bit   bad;
    bit   want;
    if (rst) begin
      pop        <= 1'b0;
      pop_mode   = 0;
      mode_timer = 30;
      hold_left  = 0;
    end else begin
      if (pop && !empty) begin
        reports_taken++;
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRORS)
            $display("result beat %0d with nothing predicted: kind %0d key %0d",
                     reports_taken, report_kind, key_out);
        end else begin
          exp_report = expected_reports.pop_front();
          bad = (report_kind != exp_report.kind) || (key_out != exp_report.key) ||
                (chord_hits != exp_report.hits) || (terminate != exp_report.term) ||
                (overflow != exp_report.ovf);
          if (bad) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_ERRORS)
              $display({"result beat %0d mismatch: expected kind %0d key %0d hits %b ",
                        "term %b ovf %b, got kind %0d key %0d hits %b term %b ovf %b"},
                       reports_taken, exp_report.kind, exp_report.key, exp_report.hits,
                       exp_report.term, exp_report.ovf, report_kind, key_out,
                       chord_hits, terminate, overflow);
          end
        end
        // long hold-off so the command queue fills and full rises
        if (reports_taken == HOLD_AT_1 || reports_taken == HOLD_AT_2)
          hold_left = HOLD_CYCLES;
      end
      mode_timer--;
      if (mode_timer <= 0) begin
        pop_mode   = $urandom_range(0, 3);
        mode_timer = $urandom_range(10, 60);
      end
      case (pop_mode)
        0:       want = 1'b1;
        1:       want = 1'($urandom_range(0, 1));
        2:       want = ($urandom_range(0, 5) == 0);
        default: want = (mode_timer % 6) < 3;
      endcase
      if (hold_left > 0) begin
        hold_left--;
        want = 1'b0;
      end
      pop <= want;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any beat on any channel restarts the count
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_event(logic [CLASS_W-1:0] cls, logic [ACTION_W-1:0] act,
                             logic [KEY_W-1:0] key);
    key_event_t ev;
    ev.cls = cls;
    ev.act = act;
    ev.key = key;
    pending_events.push_back(ev);
    if (cls == KEY_CLASS && act != ACT_OTHER) handled_queued++;
  endtask

  task automatic key_down(logic [KEY_W-1:0] key);
    queue_event(KEY_CLASS, ACT_PRESS, key);
  endtask

  task automatic key_up(logic [KEY_W-1:0] key);
    queue_event(KEY_CLASS, ACT_RELEASE, key);
  endtask

  task automatic key_repeat(logic [KEY_W-1:0] key);
    queue_event(KEY_CLASS, ACT_REPEAT, key);
  endtask

  function automatic logic [KEY_W-1:0] pool_key();
    return key_pool[$urandom_range(0, 5)];
  endfunction

  // add up to three repeats over the pressed keys, or over pool keys if none, then release
  // them in random order; now and then one key stays down as a stray
  task automatic hold_and_release(logic [KEY_W-1:0] keys [$]);
    int idx;
    repeat ($urandom_range(0, 3)) begin
      if (keys.size() > 0) key_repeat(keys[$urandom_range(0, keys.size() - 1)]);
      else key_repeat(pool_key());
    end
    while (keys.size() > 0) begin
      idx = $urandom_range(0, keys.size() - 1);
      if (keys.size() == 1 && $urandom_range(0, 5) == 0) stray_keys.push_back(keys[idx]);
      else key_up(keys[idx]);
      keys.delete(idx);
    end
  endtask

  // well-formed chord: keys in pattern order, sometimes broken by an extra key
  task automatic play_chord(logic [PAT_W-1:0] pat);
    logic [KEY_W-1:0] keys [$];
    int i;
    int len;
    len = 32'(pat[PAT_LEN_W-1:0]);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        keys.push_back(pool_key());
        key_down(keys[keys.size() - 1]);
      end
      keys.push_back(chord_slot(pat, i));
      key_down(chord_slot(pat, i));
    end
    hold_and_release(keys);
  endtask

  // more presses than the held list takes
  task automatic fill_held();
    logic [KEY_W-1:0] keys [$];
    repeat (HELD_DEPTH + 1) begin
      keys.push_back($urandom_range(0, 1) ? pool_key() : KEY_W'($urandom_range(0, 1023)));
      key_down(keys[keys.size() - 1]);
    end
    hold_and_release(keys);
  endtask

  // more distinct repeats than the repeat list takes, then clear them
  task automatic repeat_storm();
    logic [KEY_W-1:0] keys [$];
    repeat (REPEAT_DEPTH + 1) begin
      keys.push_back(KEY_W'($urandom_range(0, 1023)));
      key_repeat(keys[keys.size() - 1]);
    end
    key_repeat(keys[0]);
    foreach (keys[i]) key_up(keys[i]);
  endtask

  task automatic add_noise();
    logic [CLASS_W-1:0]  cls;
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    key;
    cls = ($urandom_range(0, 5) == 0) ? CLASS_W'($urandom_range(0, 31)) : KEY_CLASS;
    act = ACTION_W'($urandom_range(0, 3));
    key = $urandom_range(0, 1) ? pool_key() : KEY_W'($urandom_range(0, 1023));
    queue_event(cls, act, key);
    if (cls == KEY_CLASS && act == ACT_PRESS) stray_keys.push_back(key);
  endtask

  // sender pause: nothing pending and every predicted beat popped
  task automatic wait_idle();
    while (pending_events.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [PAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chord_regs[idx] = data;
  endtask

  task automatic set_chords(logic [PAT_W-1:0] a, logic [PAT_W-1:0] b,
                            logic [PAT_W-1:0] c, logic [PAT_W-1:0] x);
    write_reg(REG_CHORD_A, a);
    write_reg(REG_CHORD_B, b);
    write_reg(REG_CHORD_C, c);
    write_reg(REG_EXIT_CHORD, x);
  endtask

  // random part of one phase: mostly chords, some noise, list overflows
  task automatic run_phase(int n_events);
    int start;
    start = handled_queued;
    while (handled_queued - start < n_events) begin
      if (stray_keys.size() > 2) begin
        foreach (stray_keys[i]) key_up(stray_keys[i]);
        stray_keys.delete();
      end
      case ($urandom_range(0, 9))
        6, 7:    repeat ($urandom_range(1, 4)) add_noise();
        8:       fill_held();
        9:       repeat_storm();
        default: play_chord(chord_regs[$urandom_range(0, 3)]);
      endcase
    end
    wait_idle();
  endtask

  task automatic random_pool();
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(0, 1023));
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    logic [KEY_W-1:0] fill_keys [6];
    chord_regs[REG_CHORD_A]    = CHORD_A_RESET;
    chord_regs[REG_CHORD_B]    = CHORD_B_RESET;
    chord_regs[REG_CHORD_C]    = CHORD_C_RESET;
    chord_regs[REG_EXIT_CHORD] = EXIT_CHORD_RESET;
    list_len[LIST_HELD]   = 0;
    list_len[LIST_REPEAT] = 0;
    handled_queued = 0;
    mismatch_count = 0;
    reports_taken  = 0;
    fill_keys = '{10'd0, 10'h3FF, 10'd1, 10'd2, 10'd3, 10'd4};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part on the reset patterns
    key_down(10'd25);
    key_down(10'd18);                        // first chord held
    key_repeat(10'd18);                      // first repeat reported
    key_repeat(10'd18);                      // second repeat quiet, chords still compared
    key_up(10'd25);
    key_down(10'd45);                        // held 18 then 45: exit chord
    key_up(10'd18);                          // drops 18 from the repeat list too
    queue_event(5'd31, ACT_PRESS, 10'h3FF);  // not the key class
    queue_event(KEY_CLASS, ACT_OTHER, 10'd0);
    key_up(10'd45);                          // held list empty again
    foreach (fill_keys[i]) key_down(fill_keys[i]);
    key_down(10'd5);                         // held list full: overflow
    foreach (fill_keys[i]) key_repeat(fill_keys[i]);
    key_repeat(10'd5);                       // not held and repeat list full
    foreach (fill_keys[i]) key_up(fill_keys[i]);
    key_up(10'd5);                           // release of a key not held
    wait_idle();

    // random chords over a random key pool, one empty pattern
    random_pool();
    set_chords(make_pattern(2'd2, key_pool[0], key_pool[1], KEY_W'($urandom)),
               make_pattern(2'd3, key_pool[2], key_pool[3], key_pool[4]),
               32'h0000_0000,
               make_pattern(2'd1, key_pool[5], KEY_W'($urandom), KEY_W'($urandom)));
    run_phase(350);

    // overlapping chords; the first long hold-off lands here
    random_pool();
    set_chords(make_pattern(2'd3, key_pool[0], key_pool[1], key_pool[2]),
               make_pattern(2'd2, key_pool[1], key_pool[0], KEY_W'($urandom)),
               make_pattern(2'd1, key_pool[3], KEY_W'($urandom), KEY_W'($urandom)),
               make_pattern(2'd3, key_pool[3], key_pool[4], key_pool[5]));
    run_phase(350);

    // extreme key codes and an all-ones pattern
    random_pool();
    key_pool[0] = 10'h3FF;
    key_pool[1] = 10'd0;
    set_chords(32'hFFFF_FFFF,
               make_pattern(2'd2, 10'd0, 10'h3FF, KEY_W'($urandom)),
               {30'($urandom), 2'd0},
               make_pattern(2'd3, key_pool[2], 10'h3FF, 10'd0));
    run_phase(350);

    // back to the default patterns
    key_pool = '{10'd25, 10'd18, 10'd46, 10'd16, 10'd48, 10'd45};
    set_chords(CHORD_A_RESET, CHORD_B_RESET, CHORD_C_RESET, EXIT_CHORD_RESET);
    run_phase(350);

    // drain, then wait for any stray beat to show up
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
